[design/assert_macros.svh]
// Assertion macros shared by the effective address unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a bare property on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/cea_pkg.sv]
// Types and constants for the effective address unit.
`timescale 1ns / 1ps

package cea_pkg;

    localparam int ADDR_W = 24;
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 5;

    // Addressing mode codes
    typedef enum logic [CMD_W-1:0] {
        MODE_ABS             = 5'd0,
        MODE_ABS_LONG        = 5'd1,
        MODE_DIR             = 5'd2,
        MODE_DIR_IND_Y       = 5'd3,
        MODE_DIR_IND_LONG_Y  = 5'd4,
        MODE_DIR_X_IND       = 5'd5,
        MODE_DIR_X           = 5'd6,
        MODE_DIR_Y           = 5'd7,
        MODE_ABS_X           = 5'd8,
        MODE_ABS_Y           = 5'd9,
        MODE_ABS_LONG_X      = 5'd10,
        MODE_REL             = 5'd11,
        MODE_REL_LONG        = 5'd12,
        MODE_ABS_IND         = 5'd13,
        MODE_DIR_IND         = 5'd14,
        MODE_DIR_IND_LONG    = 5'd15,
        MODE_ABS_X_IND       = 5'd16,
        MODE_STACK_REL       = 5'd17,
        MODE_STACK_REL_IND_Y = 5'd18
    } t_mode;

    // One address request
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] operand_bytes;
        logic [WORD_W-1:0] direct_page;
        logic [BYTE_W-1:0] data_bank;
        logic [BYTE_W-1:0] program_bank;
        logic [WORD_W-1:0] program_counter;
        logic [WORD_W-1:0] stack_pointer;
        logic [WORD_W-1:0] x_index;
        logic [WORD_W-1:0] y_index;
        logic              index_is_8bit;
        logic [ADDR_W-1:0] pointer_value;
    } t_ea_req;

    // One address result
    typedef struct packed {
        logic [ADDR_W-1:0] pointer_address;
        logic              uses_pointer;
        logic              pointer_is_long;
        logic [ADDR_W-1:0] effective_address;
    } t_ea_rsp;

endpackage

[design/cea_in_reg.sv]
// Input register stage holding one address request beat.
`timescale 1ns / 1ps

module cea_in_reg
    import cea_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_ea_req i_req,
    output logic    o_valid,
    input  logic    i_ready,
    output t_ea_req o_req
);

    logic    r_valid;
    logic    n_valid;
    t_ea_req r_req;

    // Take a new beat whenever the stage is empty or drains this cycle
    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load payload on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

[design/cea_addr_calc.sv]
// Address arithmetic for all addressing modes.
`timescale 1ns / 1ps

module cea_addr_calc
    import cea_pkg::*;
(
    input  t_ea_req i_req,
    output t_ea_rsp o_rsp
);

    logic [BYTE_W-1:0] op8;
    logic [WORD_W-1:0] op16;
    logic [WORD_W-1:0] xi;
    logic [WORD_W-1:0] yi;
    logic [WORD_W-1:0] pword;
    logic [WORD_W-1:0] direct;
    logic [WORD_W-1:0] direct_x;
    logic [WORD_W-1:0] direct_y;
    logic [WORD_W-1:0] stack_rel;
    logic [WORD_W-1:0] rel_off;
    logic [ADDR_W-1:0] xi_ext;
    logic [ADDR_W-1:0] yi_ext;
    logic [ADDR_W-1:0] abs_db;
    logic [ADDR_W-1:0] ptr_db;

    // Split operand and narrow the index registers
    assign op8    = i_req.operand_bytes[BYTE_W-1:0];
    assign op16   = i_req.operand_bytes[WORD_W-1:0];
    assign pword  = i_req.pointer_value[WORD_W-1:0];
    assign xi     = i_req.index_is_8bit ? {{BYTE_W{1'b0}}, i_req.x_index[BYTE_W-1:0]}
                                        : i_req.x_index;
    assign yi     = i_req.index_is_8bit ? {{BYTE_W{1'b0}}, i_req.y_index[BYTE_W-1:0]}
                                        : i_req.y_index;
    assign xi_ext = {{BYTE_W{1'b0}}, xi};
    assign yi_ext = {{BYTE_W{1'b0}}, yi};

    // Bank-0 sums wrap at 16 bits
    assign direct    = i_req.direct_page + {{BYTE_W{1'b0}}, op8};
    assign direct_x  = direct + xi;
    assign direct_y  = direct + yi;
    assign stack_rel = i_req.stack_pointer + {{BYTE_W{1'b0}}, op8};
    assign rel_off   = {{BYTE_W{op8[BYTE_W-1]}}, op8};

    assign abs_db = {i_req.data_bank, op16};
    assign ptr_db = {i_req.data_bank, pword};

    // Select per mode; unused codes give an all-zero result
    always_comb begin
        o_rsp = '0;
        unique case (t_mode'(i_req.cmd))
            MODE_ABS: begin
                o_rsp.effective_address = abs_db;
            end
            MODE_ABS_LONG: begin
                o_rsp.effective_address = i_req.operand_bytes;
            end
            MODE_DIR: begin
                o_rsp.effective_address = {{BYTE_W{1'b0}}, direct};
            end
            MODE_DIR_IND_Y: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, direct};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.effective_address = ptr_db + yi_ext;
            end
            MODE_DIR_IND_LONG_Y: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, direct};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.pointer_is_long   = 1'b1;
                o_rsp.effective_address = i_req.pointer_value + yi_ext;
            end
            MODE_DIR_X_IND: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, direct_x};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.effective_address = ptr_db;
            end
            MODE_DIR_X: begin
                o_rsp.effective_address = {{BYTE_W{1'b0}}, direct_x};
            end
            MODE_DIR_Y: begin
                o_rsp.effective_address = {{BYTE_W{1'b0}}, direct_y};
            end
            MODE_ABS_X: begin
                o_rsp.effective_address = abs_db + xi_ext;
            end
            MODE_ABS_Y: begin
                o_rsp.effective_address = abs_db + yi_ext;
            end
            MODE_ABS_LONG_X: begin
                o_rsp.effective_address = i_req.operand_bytes + xi_ext;
            end
            MODE_REL: begin
                o_rsp.effective_address =
                    {{BYTE_W{1'b0}}, WORD_W'(i_req.program_counter + rel_off)};
            end
            MODE_REL_LONG: begin
                o_rsp.effective_address =
                    {{BYTE_W{1'b0}}, WORD_W'(i_req.program_counter + op16)};
            end
            MODE_ABS_IND: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, op16};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.effective_address = {i_req.program_bank, pword};
            end
            MODE_DIR_IND: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, direct};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.effective_address = ptr_db;
            end
            MODE_DIR_IND_LONG: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, direct};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.pointer_is_long   = 1'b1;
                o_rsp.effective_address = i_req.pointer_value;
            end
            MODE_ABS_X_IND: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, WORD_W'(op16 + xi)};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.effective_address = {{BYTE_W{1'b0}}, pword};
            end
            MODE_STACK_REL: begin
                o_rsp.effective_address = {{BYTE_W{1'b0}}, stack_rel};
            end
            MODE_STACK_REL_IND_Y: begin
                o_rsp.pointer_address   = {{BYTE_W{1'b0}}, stack_rel};
                o_rsp.uses_pointer      = 1'b1;
                o_rsp.effective_address = ptr_db + yi_ext;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

[design/cea_out_reg.sv]
// Result register stage holding one address result beat.
`timescale 1ns / 1ps

module cea_out_reg
    import cea_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_ea_rsp i_rsp,
    output logic    o_valid,
    input  logic    i_ready,
    output t_ea_rsp o_rsp
);

    logic    r_valid;
    logic    n_valid;
    t_ea_rsp r_rsp;

    // Refill as the consumer drains the current beat
    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture result on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

[design/cpu16_effective_address_unit.sv]
// Top level of the 24-bit effective address unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one request per cycle while o_ready is high and returns one result per
// request. An accepted request is captured in the input register, the mode adders
// and selection feed the result register, and the result is registered there
// before it appears on the outputs. Throughput is one beat per clock as long as the
// consumer keeps i_ready high; a stall on the result side backs up through the two
// registers to o_ready. The pointer is not read here: the caller supplies
// pointer_value together with the request, and the result reports where that
// pointer lives and whether it is two or three bytes.
module cpu16_effective_address_unit
    import cea_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ADDR_W-1:0] i_operand_bytes,
    input  logic [WORD_W-1:0] i_direct_page,
    input  logic [BYTE_W-1:0] i_data_bank,
    input  logic [BYTE_W-1:0] i_program_bank,
    input  logic [WORD_W-1:0] i_program_counter,
    input  logic [WORD_W-1:0] i_stack_pointer,
    input  logic [WORD_W-1:0] i_x_index,
    input  logic [WORD_W-1:0] i_y_index,
    input  logic              i_index_is_8bit,
    input  logic [ADDR_W-1:0] i_pointer_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_pointer_address,
    output logic              o_uses_pointer,
    output logic              o_pointer_is_long,
    output logic [ADDR_W-1:0] o_effective_address
);

    t_ea_req in_req;
    t_ea_req stg_req;
    t_ea_rsp calc_rsp;
    t_ea_rsp out_rsp;
    logic    stg_valid;
    logic    stg_ready;

    // Gather the request fields
    always_comb begin
        in_req.cmd             = i_cmd;
        in_req.operand_bytes   = i_operand_bytes;
        in_req.direct_page     = i_direct_page;
        in_req.data_bank       = i_data_bank;
        in_req.program_bank    = i_program_bank;
        in_req.program_counter = i_program_counter;
        in_req.stack_pointer   = i_stack_pointer;
        in_req.x_index         = i_x_index;
        in_req.y_index         = i_y_index;
        in_req.index_is_8bit   = i_index_is_8bit;
        in_req.pointer_value   = i_pointer_value;
    end

    cea_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (in_req),
        .o_valid (stg_valid),
        .i_ready (stg_ready),
        .o_req   (stg_req)
    );

    cea_addr_calc u_addr_calc (
        .i_req (stg_req),
        .o_rsp (calc_rsp)
    );

    cea_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid),
        .o_ready (stg_ready),
        .i_rsp   (calc_rsp),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (out_rsp)
    );

    // Drive the result fields
    assign o_pointer_address   = out_rsp.pointer_address;
    assign o_uses_pointer      = out_rsp.uses_pointer;
    assign o_pointer_is_long   = out_rsp.pointer_is_long;
    assign o_effective_address = out_rsp.effective_address;

    // A draining consumer never stalls the request side
    `ASSERT_IMPL(a_no_bubble, i_clk, i_rst_n, i_ready, o_ready, "request side stalled")
    // A staged request moves to the result register when there is room
    `ASSERT_NEXT(a_stage_advance, i_clk, i_rst_n, stg_valid && stg_ready, o_valid, "beat lost")
    // A long pointer is always a pointer
    `ASSERT_IMPL(a_long_ptr, i_clk, i_rst_n, o_valid && o_pointer_is_long,
                 o_uses_pointer, "long without pointer")
    // Modes without a pointer report no pointer address
    `ASSERT_IMPL(a_no_ptr_addr, i_clk, i_rst_n, o_valid && !o_uses_pointer,
                 o_pointer_address == '0, "stray pointer address")

endmodule

[verif/tb_cpu16_effective_address_unit.sv]
// Self-checking testbench for the 24-bit effective address unit.
`timescale 1ns / 1ps

module tb_cpu16_effective_address_unit
    import cea_pkg::*;
();

    // Mode codes past the last defined addressing mode
    localparam logic [CMD_W-1:0] MODE_FIRST_UNUSED = 5'd19;
    localparam logic [CMD_W-1:0] MODE_LAST_CODE    = 5'd31;

    localparam int MAX_IDLE       = 18;
    localparam int RANDOM_BLOCKS  = 17;
    localparam int BLOCK_ITEMS    = 100;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [CMD_W-1:0]  i_cmd;
    logic [ADDR_W-1:0] i_operand_bytes;
    logic [WORD_W-1:0] i_direct_page;
    logic [BYTE_W-1:0] i_data_bank;
    logic [BYTE_W-1:0] i_program_bank;
    logic [WORD_W-1:0] i_program_counter;
    logic [WORD_W-1:0] i_stack_pointer;
    logic [WORD_W-1:0] i_x_index;
    logic [WORD_W-1:0] i_y_index;
    logic              i_index_is_8bit;
    logic [ADDR_W-1:0] i_pointer_value;
    logic              o_valid;
    logic              i_ready;
    logic [ADDR_W-1:0] o_pointer_address;
    logic              o_uses_pointer;
    logic              o_pointer_is_long;
    logic [ADDR_W-1:0] o_effective_address;

    t_ea_rsp pending_addresses[$];
    int      mismatch_count = 0;
    int      stalled_cycles = 0;
    logic    gaps_enabled   = 1'b1;

    cpu16_effective_address_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cmd               (i_cmd),
        .i_operand_bytes     (i_operand_bytes),
        .i_direct_page       (i_direct_page),
        .i_data_bank         (i_data_bank),
        .i_program_bank      (i_program_bank),
        .i_program_counter   (i_program_counter),
        .i_stack_pointer     (i_stack_pointer),
        .i_x_index           (i_x_index),
        .i_y_index           (i_y_index),
        .i_index_is_8bit     (i_index_is_8bit),
        .i_pointer_value     (i_pointer_value),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_pointer_address   (o_pointer_address),
        .o_uses_pointer      (o_uses_pointer),
        .o_pointer_is_long   (o_pointer_is_long),
        .o_effective_address (o_effective_address)
    );

    // Free-running 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Compute pointer location and final address for one access
    function automatic t_ea_rsp compute_effective_address(input t_ea_req req);
        logic [ADDR_W-1:0] db_base;
        logic [ADDR_W-1:0] pb_base;
        logic [WORD_W-1:0] ptr_word;
        logic [WORD_W-1:0] op_word;
        logic [WORD_W-1:0] x_sel;
        logic [WORD_W-1:0] y_sel;
        logic [WORD_W-1:0] direct;
        logic [WORD_W-1:0] wrapped;
        logic [ADDR_W-1:0] ptr_wide;
        logic [ADDR_W-1:0] op_wide;
        logic [ADDR_W-1:0] x_wide;
        logic [ADDR_W-1:0] y_wide;
        logic [ADDR_W-1:0] direct_wide;
        t_ea_rsp           rsp;
        db_base     = {req.data_bank, 16'h0000};
        pb_base     = {req.program_bank, 16'h0000};
        ptr_word    = req.pointer_value[15:0];
        op_word     = req.operand_bytes[15:0];
        x_sel       = req.index_is_8bit ? {8'h00, req.x_index[7:0]} : req.x_index;
        y_sel       = req.index_is_8bit ? {8'h00, req.y_index[7:0]} : req.y_index;
        direct      = req.direct_page + {8'h00, req.operand_bytes[7:0]};
        ptr_wide    = {8'h00, ptr_word};
        op_wide     = {8'h00, op_word};
        x_wide      = {8'h00, x_sel};
        y_wide      = {8'h00, y_sel};
        direct_wide = {8'h00, direct};
        rsp         = '0;
        case (req.cmd)
            MODE_ABS: begin
                rsp.effective_address = db_base | op_wide;
            end
            MODE_ABS_LONG: begin
                rsp.effective_address = req.operand_bytes;
            end
            MODE_DIR: begin
                rsp.effective_address = direct_wide;
            end
            MODE_DIR_IND_Y: begin
                rsp.pointer_address   = direct_wide;
                rsp.uses_pointer      = 1'b1;
                rsp.effective_address = (db_base | ptr_wide) + y_wide;
            end
            MODE_DIR_IND_LONG_Y: begin
                rsp.pointer_address   = direct_wide;
                rsp.uses_pointer      = 1'b1;
                rsp.pointer_is_long   = 1'b1;
                rsp.effective_address = req.pointer_value + y_wide;
            end
            MODE_DIR_X_IND: begin
                wrapped               = direct + x_sel;
                rsp.pointer_address   = {8'h00, wrapped};
                rsp.uses_pointer      = 1'b1;
                rsp.effective_address = db_base | ptr_wide;
            end
            MODE_DIR_X: begin
                wrapped               = direct + x_sel;
                rsp.effective_address = {8'h00, wrapped};
            end
            MODE_DIR_Y: begin
                wrapped               = direct + y_sel;
                rsp.effective_address = {8'h00, wrapped};
            end
            MODE_ABS_X: begin
                rsp.effective_address = (db_base | op_wide) + x_wide;
            end
            MODE_ABS_Y: begin
                rsp.effective_address = (db_base | op_wide) + y_wide;
            end
            MODE_ABS_LONG_X: begin
                rsp.effective_address = req.operand_bytes + x_wide;
            end
            MODE_REL: begin
                // Branch offset is a signed byte
                wrapped = req.program_counter
                        + {{8{req.operand_bytes[7]}}, req.operand_bytes[7:0]};
                rsp.effective_address = {8'h00, wrapped};
            end
            MODE_REL_LONG: begin
                wrapped               = req.program_counter + op_word;
                rsp.effective_address = {8'h00, wrapped};
            end
            MODE_ABS_IND: begin
                rsp.pointer_address   = op_wide;
                rsp.uses_pointer      = 1'b1;
                rsp.effective_address = pb_base | ptr_wide;
            end
            MODE_DIR_IND: begin
                rsp.pointer_address   = direct_wide;
                rsp.uses_pointer      = 1'b1;
                rsp.effective_address = db_base | ptr_wide;
            end
            MODE_DIR_IND_LONG: begin
                rsp.pointer_address   = direct_wide;
                rsp.uses_pointer      = 1'b1;
                rsp.pointer_is_long   = 1'b1;
                rsp.effective_address = req.pointer_value;
            end
            MODE_ABS_X_IND: begin
                wrapped               = op_word + x_sel;
                rsp.pointer_address   = {8'h00, wrapped};
                rsp.uses_pointer      = 1'b1;
                rsp.effective_address = ptr_wide;
            end
            MODE_STACK_REL: begin
                wrapped               = req.stack_pointer + {8'h00, req.operand_bytes[7:0]};
                rsp.effective_address = {8'h00, wrapped};
            end
            MODE_STACK_REL_IND_Y: begin
                wrapped               = req.stack_pointer + {8'h00, req.operand_bytes[7:0]};
                rsp.pointer_address   = {8'h00, wrapped};
                rsp.uses_pointer      = 1'b1;
                rsp.effective_address = (db_base | ptr_wide) + y_wide;
            end
            default: begin
                rsp = '0;
            end
        endcase
        return rsp;
    endfunction

    // Print one failure line and count it
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Draw a field value, leaning toward all-zero and all-one
    function automatic logic [ADDR_W-1:0] pick_value(input int width);
        logic [31:0] mask;
        mask = (32'h1 << width) - 32'h1;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask[ADDR_W-1:0];
            default: return ADDR_W'($urandom & mask);
        endcase
    endfunction

    // Build an access with random mode and content
    function automatic t_ea_req random_request();
        t_ea_req req;
        if ($urandom_range(0, 9) == 0) begin
            req.cmd = CMD_W'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_CODE));
        end else begin
            req.cmd = CMD_W'($urandom_range(MODE_ABS, MODE_STACK_REL_IND_Y));
        end
        req.operand_bytes   = pick_value(ADDR_W);
        req.direct_page     = WORD_W'(pick_value(WORD_W));
        req.data_bank       = BYTE_W'(pick_value(BYTE_W));
        req.program_bank    = BYTE_W'(pick_value(BYTE_W));
        req.program_counter = WORD_W'(pick_value(WORD_W));
        req.stack_pointer   = WORD_W'(pick_value(WORD_W));
        req.x_index         = WORD_W'(pick_value(WORD_W));
        req.y_index         = WORD_W'(pick_value(WORD_W));
        req.index_is_8bit   = 1'($urandom_range(0, 1));
        req.pointer_value   = pick_value(ADDR_W);
        return req;
    endfunction

    // Send one beat: idle for a drawn gap, then hold until accepted
    task automatic send_access(input t_ea_req req);
        int gap;
        gap = gaps_enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_cmd             <= req.cmd;
        i_operand_bytes   <= req.operand_bytes;
        i_direct_page     <= req.direct_page;
        i_data_bank       <= req.data_bank;
        i_program_bank    <= req.program_bank;
        i_program_counter <= req.program_counter;
        i_stack_pointer   <= req.stack_pointer;
        i_x_index         <= req.x_index;
        i_y_index         <= req.y_index;
        i_index_is_8bit   <= req.index_is_8bit;
        i_pointer_value   <= req.pointer_value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and hold until every outstanding result has returned
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_addresses.size() != 0) @(posedge i_clk);
    endtask

    // Every mode with all other fields at their maximum, the index width alternating by mode
    task automatic test_mode_sweep();
        t_ea_req req;
        for (int m = MODE_ABS; m <= MODE_STACK_REL_IND_Y; m++) begin
            req               = '1;
            req.cmd           = CMD_W'(m);
            req.index_is_8bit = m[0];
            send_access(req);
        end
    endtask

    // All-zero access, both branch directions and the first and last unused mode codes
    task automatic test_corner_cases();
        t_ea_req req;
        req = '0;
        send_access(req);
        req.cmd             = MODE_REL;
        req.program_counter = 16'h0005;
        req.operand_bytes   = 24'hFFFF7F;
        send_access(req);
        req.operand_bytes   = 24'h000080;
        send_access(req);
        req     = '1;
        req.cmd = MODE_FIRST_UNUSED;
        send_access(req);
        req.cmd = MODE_LAST_CODE;
        send_access(req);
    endtask

    // Hold off the sender once until the pipeline has fully drained
    task automatic test_drain_pause();
        repeat (20) send_access(random_request());
        wait_for_drain();
        repeat (20) send_access(random_request());
    endtask

    // Random traffic in blocks, some with no idling on either side
    task automatic test_random_traffic();
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            gaps_enabled = ($urandom_range(0, 3) != 0);
            repeat (BLOCK_ITEMS) send_access(random_request());
        end
        gaps_enabled = 1'b1;
    endtask

    // Result side: stall for a drawn number of cycles per beat
    initial begin : result_sink
        int stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = gaps_enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Record accepted requests, check returned beats, count quiet cycles
    always @(posedge i_clk) begin
        t_ea_req req;
        t_ea_rsp want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                req = {i_cmd, i_operand_bytes, i_direct_page, i_data_bank,
                       i_program_bank, i_program_counter, i_stack_pointer,
                       i_x_index, i_y_index, i_index_is_8bit, i_pointer_value};
                pending_addresses.push_back(compute_effective_address(req));
            end
            if (o_valid && i_ready) begin
                if (pending_addresses.size() == 0) begin
                    report_error("result beat with nothing outstanding");
                end else begin
                    want = pending_addresses.pop_front();
                    if (o_pointer_address !== want.pointer_address)
                        report_error($sformatf("pointer_address got %06h want %06h",
                                               o_pointer_address, want.pointer_address));
                    if (o_uses_pointer !== want.uses_pointer)
                        report_error($sformatf("uses_pointer got %0b want %0b",
                                               o_uses_pointer, want.uses_pointer));
                    if (o_pointer_is_long !== want.pointer_is_long)
                        report_error($sformatf("pointer_is_long got %0b want %0b",
                                               o_pointer_is_long, want.pointer_is_long));
                    if (o_effective_address !== want.effective_address)
                        report_error($sformatf("effective_address got %06h want %06h",
                                               o_effective_address,
                                               want.effective_address));
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Abort when no beat moves on either side for too long
    initial begin : watchdog
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Reset, run each test in turn, drain and report
    initial begin
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_cmd             <= '0;
        i_operand_bytes   <= '0;
        i_direct_page     <= '0;
        i_data_bank       <= '0;
        i_program_bank    <= '0;
        i_program_counter <= '0;
        i_stack_pointer   <= '0;
        i_x_index         <= '0;
        i_y_index         <= '0;
        i_index_is_8bit   <= 1'b0;
        i_pointer_value   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mode_sweep();
        test_corner_cases();
        test_drain_pause();
        test_random_traffic();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_addresses.size() != 0)
            report_error($sformatf("%0d results never returned", pending_addresses.size()));
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
